>>> rtl/cql_pkg.sv
`timescale 1ns / 1ps

package cql_pkg;

    localparam int DATA_WIDTH_DEF  = 32;
    localparam int FRAC_BITS_DEF   = 24;
    localparam int COUNT_WIDTH_DEF = 16;
    localparam int SUM_WIDTH       = 48;
    localparam int NUM_REGS        = 7;

    typedef enum logic [2:0] {
        REG_MODEL_KIND  = 3'd0,
        REG_INTERCEPT   = 3'd1,
        REG_PERSISTENCE = 3'd2,
        REG_POS_COEF    = 3'd3,
        REG_NEG_COEF    = 3'd4,
        REG_RISK_LEVEL  = 3'd5,
        REG_INIT_QUANT  = 3'd6
    } reg_idx_t;

    typedef struct packed {
        logic start;
        logic neg;
    } mul_ctl_t;

endpackage

>>> rtl/cql_regs.sv
`timescale 1ns / 1ps

module cql_regs #(
    parameter int DATA_WIDTH = cql_pkg::DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = cql_pkg::FRAC_BITS_DEF,
    parameter int PDATA_W    = 32,
    parameter int ADDR_W     = 5
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [ADDR_W-1:0]     paddr,
    input  logic [PDATA_W-1:0]    pwdata,
    output logic [PDATA_W-1:0]    prdata,
    output logic                  model_kind,
    output logic [DATA_WIDTH-1:0] intercept,
    output logic [DATA_WIDTH-1:0] persistence,
    output logic [DATA_WIDTH-1:0] pos_coef,
    output logic [DATA_WIDTH-1:0] neg_coef,
    output logic [FRAC_BITS:0]    risk_level,
    output logic [DATA_WIDTH-1:0] initial_quantile
);

    localparam int SL = $clog2(PDATA_W / 8);
    localparam logic [FRAC_BITS:0] RISK_RESET =
        (FRAC_BITS+1)'(((64'd1 << FRAC_BITS) * 64'd5 + 64'd50) / 64'd100);

    logic                  model_kind_reg;
    logic [DATA_WIDTH-1:0] intercept_reg;
    logic [DATA_WIDTH-1:0] persistence_reg;
    logic [DATA_WIDTH-1:0] pos_coef_reg;
    logic [DATA_WIDTH-1:0] neg_coef_reg;
    logic [FRAC_BITS:0]    risk_level_reg;
    logic [DATA_WIDTH-1:0] init_q_reg;
    cql_pkg::reg_idx_t     idx;
    logic                  wr;

    assign idx = cql_pkg::reg_idx_t'(paddr[ADDR_W-1:SL]);
    assign wr  = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            model_kind_reg  <= 1'b0;
            intercept_reg   <= '0;
            persistence_reg <= '0;
            pos_coef_reg    <= '0;
            neg_coef_reg    <= '0;
            risk_level_reg  <= RISK_RESET;
            init_q_reg      <= '0;
        end
        else if (wr)
        begin
            case (idx)
                cql_pkg::REG_MODEL_KIND:  model_kind_reg  <= pwdata[0];
                cql_pkg::REG_INTERCEPT:   intercept_reg   <= pwdata[DATA_WIDTH-1:0];
                cql_pkg::REG_PERSISTENCE: persistence_reg <= pwdata[DATA_WIDTH-1:0];
                cql_pkg::REG_POS_COEF:    pos_coef_reg    <= pwdata[DATA_WIDTH-1:0];
                cql_pkg::REG_NEG_COEF:    neg_coef_reg    <= pwdata[DATA_WIDTH-1:0];
                cql_pkg::REG_RISK_LEVEL:  risk_level_reg  <= pwdata[FRAC_BITS:0];
                cql_pkg::REG_INIT_QUANT:  init_q_reg      <= pwdata[DATA_WIDTH-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            cql_pkg::REG_MODEL_KIND:  prdata = PDATA_W'(model_kind_reg);
            cql_pkg::REG_INTERCEPT:   prdata = PDATA_W'(intercept_reg);
            cql_pkg::REG_PERSISTENCE: prdata = PDATA_W'(persistence_reg);
            cql_pkg::REG_POS_COEF:    prdata = PDATA_W'(pos_coef_reg);
            cql_pkg::REG_NEG_COEF:    prdata = PDATA_W'(neg_coef_reg);
            cql_pkg::REG_RISK_LEVEL:  prdata = PDATA_W'(risk_level_reg);
            cql_pkg::REG_INIT_QUANT:  prdata = PDATA_W'(init_q_reg);
            default:                  prdata = '0;
        endcase
    end

    assign model_kind       = model_kind_reg;
    assign intercept        = intercept_reg;
    assign persistence      = persistence_reg;
    assign pos_coef         = pos_coef_reg;
    assign neg_coef         = neg_coef_reg;
    assign risk_level       = risk_level_reg;
    assign initial_quantile = init_q_reg;

endmodule

>>> rtl/cql_mul.sv
`timescale 1ns / 1ps

// sign-magnitude multiply, two half-width passes, floor(a*b >> FRAC_BITS)
module cql_mul #(
    parameter int DATA_WIDTH = cql_pkg::DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = cql_pkg::FRAC_BITS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  cql_pkg::mul_ctl_t     ctl,
    input  logic [((DATA_WIDTH > FRAC_BITS+1) ? DATA_WIDTH : FRAC_BITS+1)-1:0] a_mag,
    input  logic [((DATA_WIDTH > FRAC_BITS+1) ? DATA_WIDTH : FRAC_BITS+1)-1:0] b_mag,
    output logic                  done,
    output logic [DATA_WIDTH-1:0] res_s,
    output logic [DATA_WIDTH-1:0] res_u
);

    localparam int MW  = (DATA_WIDTH > FRAC_BITS+1) ? DATA_WIDTH : FRAC_BITS+1;
    localparam int HW  = (MW + 1) / 2;
    localparam int LW  = MW - HW;
    localparam int PW  = 2 * MW;
    localparam int SHW = PW - FRAC_BITS;

    localparam logic [SHW:0] DMAX_X  = {{(SHW+2-DATA_WIDTH){1'b0}}, {(DATA_WIDTH-1){1'b1}}};
    localparam logic [SHW:0] DMINM_X =
        {{(SHW+1-DATA_WIDTH){1'b0}}, 1'b1, {(DATA_WIDTH-1){1'b0}}};
    localparam logic [SHW:0] DMASK_X = {{(SHW+1-DATA_WIDTH){1'b0}}, {DATA_WIDTH{1'b1}}};
    localparam logic [DATA_WIDTH-1:0] DMAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
    localparam logic [DATA_WIDTH-1:0] DMIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};

    typedef enum logic [1:0] {
        M_IDLE,
        M_LO,
        M_HI,
        M_POST
    } mstate_t;

    mstate_t               state_reg;
    logic                  done_reg;
    logic [MW-1:0]         a_reg;
    logic [MW-1:0]         b_reg;
    logic                  neg_reg;
    logic [PW-1:0]         prod_reg;
    logic [DATA_WIDTH-1:0] res_s_reg;
    logic [DATA_WIDTH-1:0] res_u_reg;

    logic [HW-1:0]         b_part;
    logic [MW+HW-1:0]      pp;
    logic [SHW:0]          sh;
    logic [SHW:0]          rnd;
    logic [DATA_WIDTH-1:0] s_val;
    logic [DATA_WIDTH-1:0] u_val;

    assign b_part = (state_reg == M_LO) ? b_reg[HW-1:0] : HW'(b_reg[MW-1:HW]);
    assign pp     = a_reg * b_part;

    assign sh  = {1'b0, prod_reg[PW-1:FRAC_BITS]};
    assign rnd = sh + (SHW+1)'(|prod_reg[FRAC_BITS-1:0]);

    always_comb
    begin
        if (!neg_reg)
            s_val = (sh > DMAX_X) ? DMAX : sh[DATA_WIDTH-1:0];
        else if (rnd > DMINM_X)
            s_val = DMIN;
        else
            s_val = ~rnd[DATA_WIDTH-1:0] + 1'b1;
        u_val = (sh > DMASK_X) ? {DATA_WIDTH{1'b1}} : sh[DATA_WIDTH-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= M_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= (state_reg == M_POST);
            case (state_reg)
                M_IDLE:  if (ctl.start) state_reg <= M_LO;
                M_LO:    state_reg <= M_HI;
                M_HI:    state_reg <= M_POST;
                M_POST:  state_reg <= M_IDLE;
                default: state_reg <= M_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.start)
        begin
            a_reg   <= a_mag;
            b_reg   <= b_mag;
            neg_reg <= ctl.neg;
        end
        case (state_reg)
            M_LO:    prod_reg <= PW'(pp);
            M_HI:    prod_reg <= prod_reg + {pp[MW+LW-1:0], {HW{1'b0}}};
            M_POST:
            begin
                res_s_reg <= s_val;
                res_u_reg <= u_val;
            end
            default: ;
        endcase
    end

    assign done  = done_reg;
    assign res_s = res_s_reg;
    assign res_u = res_u_reg;

endmodule

>>> rtl/cql_div.sv
`timescale 1ns / 1ps

// restoring divider, one quotient bit per cycle
module cql_div #(
    parameter int COUNT_WIDTH = cql_pkg::COUNT_WIDTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [cql_pkg::SUM_WIDTH-1:0] dividend,
    input  logic [COUNT_WIDTH-1:0]        divisor,
    output logic                          done,
    output logic [cql_pkg::SUM_WIDTH-1:0] quotient
);

    localparam int SW    = cql_pkg::SUM_WIDTH;
    localparam int CNT_W = $clog2(SW + 1);

    logic [CNT_W-1:0]       cnt_reg;
    logic                   done_reg;
    logic [SW-1:0]          quo_reg;
    logic [COUNT_WIDTH-1:0] rem_reg;
    logic [COUNT_WIDTH-1:0] dvs_reg;
    logic [COUNT_WIDTH:0]   trial;
    logic [COUNT_WIDTH:0]   diff;
    logic                   ge;

    assign trial = {rem_reg, quo_reg[SW-1]};
    assign diff  = trial - {1'b0, dvs_reg};
    assign ge    = trial >= {1'b0, dvs_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= (cnt_reg == CNT_W'(1));
            if (start)
                cnt_reg <= CNT_W'(SW);
            else if (cnt_reg != '0)
                cnt_reg <= cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (cnt_reg != '0)
        begin
            rem_reg <= ge ? diff[COUNT_WIDTH-1:0] : trial[COUNT_WIDTH-1:0];
            quo_reg <= {quo_reg[SW-2:0], ge};
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

>>> rtl/caviar_quantile_loss_top.sv
`timescale 1ns / 1ps

// CAViaR quantile tracker with pinball loss. Each sample word gives one result word.
// The recursion and loss products of a later word, in symmetric and asymmetric
// mode alike, all run through one shared multiplier that forms each product in
// two half-width passes, then rounding and saturation. A word marked last with
// at least one loss term adds the 48-step serial divider that forms the mean.
// The input is stalled while a word is in work; a finished result sits in the
// output register, so the next word can be taken while it waits.
module caviar_quantile_loss_top #(
    parameter int DATA_WIDTH  = cql_pkg::DATA_WIDTH_DEF,
    parameter int FRAC_BITS   = cql_pkg::FRAC_BITS_DEF,
    parameter int COUNT_WIDTH = cql_pkg::COUNT_WIDTH_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [$clog2(cql_pkg::NUM_REGS *
        ((((DATA_WIDTH > FRAC_BITS+1) ? DATA_WIDTH : FRAC_BITS+1) > 32) ? 8 : 4))-1:0] paddr,
    input  logic [((((DATA_WIDTH > FRAC_BITS+1) ? DATA_WIDTH : FRAC_BITS+1) > 32)
        ? 64 : 32)-1:0]                  pwdata,
    output logic [((((DATA_WIDTH > FRAC_BITS+1) ? DATA_WIDTH : FRAC_BITS+1) > 32)
        ? 64 : 32)-1:0]                  prdata,
    output logic                         pready,
    input  logic                         smp_valid,
    output logic                         smp_stall,
    input  logic signed [DATA_WIDTH-1:0] sample,
    input  logic                         last,
    output logic                         res_valid,
    input  logic                         res_stall,
    output logic signed [DATA_WIDTH-1:0] quantile,
    output logic [DATA_WIDTH-1:0]        loss_term,
    output logic                         loss_valid,
    output logic [DATA_WIDTH-1:0]        mean_loss,
    output logic                         mean_valid,
    output logic                         count_overflow
);

    localparam int REG_W   = (DATA_WIDTH > FRAC_BITS+1) ? DATA_WIDTH : FRAC_BITS+1;
    localparam int PDATA_W = (REG_W > 32) ? 64 : 32;
    localparam int ADDR_W  = $clog2(cql_pkg::NUM_REGS * (PDATA_W / 8));
    localparam int MW      = REG_W;
    localparam int ACW     = DATA_WIDTH + 2;
    localparam int SW      = cql_pkg::SUM_WIDTH;

    localparam logic [DATA_WIDTH-1:0] DMAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
    localparam logic [DATA_WIDTH-1:0] DMIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};
    localparam logic signed [ACW-1:0] ACC_MAX = {3'b000, {(DATA_WIDTH-1){1'b1}}};
    localparam logic signed [ACW-1:0] ACC_MIN = {3'b111, {(DATA_WIDTH-1){1'b0}}};
    localparam logic [FRAC_BITS:0]    ONE_Q   = {1'b1, {FRAC_BITS{1'b0}}};
    localparam logic [SW:0]           SUM_MAX = {1'b0, {SW{1'b1}}};

    typedef enum logic [3:0] {
        S_IDLE,
        S_PERS,
        S_POS,
        S_NEG,
        S_QSAT,
        S_LOSS_GO,
        S_LOSS,
        S_FIN,
        S_DIV,
        S_OUT
    } state_t;

    function automatic logic [DATA_WIDTH-1:0] mag_of(input logic [DATA_WIDTH-1:0] v);
        return v[DATA_WIDTH-1] ? (~v + 1'b1) : v;
    endfunction

    logic                  model_kind;
    logic [DATA_WIDTH-1:0] intercept;
    logic [DATA_WIDTH-1:0] persistence;
    logic [DATA_WIDTH-1:0] pos_coef;
    logic [DATA_WIDTH-1:0] neg_coef;
    logic [FRAC_BITS:0]    risk_level;
    logic [DATA_WIDTH-1:0] initial_quantile;

    state_t                 state_reg;
    logic                   started_reg;
    logic                   ovf_reg;
    logic [COUNT_WIDTH-1:0] count_reg;
    logic [SW-1:0]          sum_reg;
    logic                   res_valid_reg;

    logic [DATA_WIDTH-1:0]  prev_q_reg;
    logic [DATA_WIDTH-1:0]  prev_r_reg;
    logic [DATA_WIDTH-1:0]  r_reg;
    logic                   last_reg;
    logic signed [ACW-1:0]  acc_reg;
    logic [DATA_WIDTH-1:0]  q_reg;
    logic [DATA_WIDTH-1:0]  loss_reg;
    logic                   lv_reg;
    logic [DATA_WIDTH-1:0]  mean_reg;
    logic                   mv_reg;

    logic [DATA_WIDTH-1:0]  quantile_reg;
    logic [DATA_WIDTH-1:0]  loss_term_reg;
    logic                   loss_valid_reg;
    logic [DATA_WIDTH-1:0]  mean_loss_reg;
    logic                   mean_valid_reg;
    logic                   count_ovf_reg;

    logic                   accept;
    logic                   out_load;
    cql_pkg::mul_ctl_t      mul_ctl;
    logic [MW-1:0]          mul_a;
    logic [MW-1:0]          mul_b;
    logic                   mul_done;
    logic [DATA_WIDTH-1:0]  mul_res_s;
    logic [DATA_WIDTH-1:0]  mul_res_u;
    logic                   div_start;
    logic                   div_done;
    logic [SW-1:0]          div_quo;

    logic signed [ACW-1:0]  acc_add;
    logic [DATA_WIDTH-1:0]  q_sat;
    logic                   r_lt_q;
    logic [DATA_WIDTH-1:0]  loss_mag;
    logic [FRAC_BITS:0]     tau;
    logic [FRAC_BITS:0]     rate;
    logic [SW:0]            sum_add;
    logic [DATA_WIDTH-1:0]  mean_sat;

    cql_regs #(
        .DATA_WIDTH (DATA_WIDTH),
        .FRAC_BITS  (FRAC_BITS),
        .PDATA_W    (PDATA_W),
        .ADDR_W     (ADDR_W)
    ) u_regs (
        .clk              (clk),
        .rst_n            (rst_n),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .model_kind       (model_kind),
        .intercept        (intercept),
        .persistence      (persistence),
        .pos_coef         (pos_coef),
        .neg_coef         (neg_coef),
        .risk_level       (risk_level),
        .initial_quantile (initial_quantile)
    );

    cql_mul #(
        .DATA_WIDTH (DATA_WIDTH),
        .FRAC_BITS  (FRAC_BITS)
    ) u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (mul_ctl),
        .a_mag (mul_a),
        .b_mag (mul_b),
        .done  (mul_done),
        .res_s (mul_res_s),
        .res_u (mul_res_u)
    );

    cql_div #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (sum_reg),
        .divisor  (count_reg),
        .done     (div_done),
        .quotient (div_quo)
    );

    assign pready    = 1'b1;
    assign smp_stall = (state_reg != S_IDLE);
    assign accept    = smp_valid && (state_reg == S_IDLE);
    assign out_load  = (state_reg == S_OUT) && (!res_valid_reg || !res_stall);
    assign div_start = (state_reg == S_FIN) && last_reg && (count_reg != '0);

    // recursion terms and loss share the multiplier
    always_comb
    begin
        mul_ctl = '0;
        mul_a   = '0;
        mul_b   = '0;
        case (state_reg)
            S_IDLE:
            begin
                mul_ctl.start = accept && started_reg;
                mul_ctl.neg   = persistence[DATA_WIDTH-1] ^ prev_q_reg[DATA_WIDTH-1];
                mul_a         = MW'(mag_of(persistence));
                mul_b         = MW'(mag_of(prev_q_reg));
            end
            S_PERS:
            begin
                mul_ctl.start = mul_done;
                mul_ctl.neg   = pos_coef[DATA_WIDTH-1];
                mul_a         = MW'(mag_of(pos_coef));
                if (model_kind)
                    mul_b = prev_r_reg[DATA_WIDTH-1] ? '0 : MW'(prev_r_reg);
                else
                    mul_b = MW'(mag_of(prev_r_reg));
            end
            S_POS:
            begin
                mul_ctl.start = mul_done && model_kind;
                mul_ctl.neg   = neg_coef[DATA_WIDTH-1] ^ prev_r_reg[DATA_WIDTH-1];
                mul_a         = MW'(mag_of(neg_coef));
                mul_b         = prev_r_reg[DATA_WIDTH-1] ? MW'(mag_of(prev_r_reg)) : '0;
            end
            S_LOSS_GO:
            begin
                mul_ctl.start = 1'b1;
                mul_a         = MW'(loss_mag);
                mul_b         = MW'(rate);
            end
            default: ;
        endcase
    end

    assign acc_add = acc_reg + {{2{mul_res_s[DATA_WIDTH-1]}}, mul_res_s};

    always_comb
    begin
        if (acc_reg > ACC_MAX)
            q_sat = DMAX;
        else if (acc_reg < ACC_MIN)
            q_sat = DMIN;
        else
            q_sat = acc_reg[DATA_WIDTH-1:0];
    end

    assign r_lt_q   = $signed(r_reg) < $signed(q_reg);
    assign loss_mag = r_lt_q ? (q_reg - r_reg) : (r_reg - q_reg);
    assign tau      = (risk_level > ONE_Q) ? ONE_Q : risk_level;
    assign rate     = r_lt_q ? (ONE_Q - tau) : tau;
    assign sum_add  = {1'b0, sum_reg} + (SW+1)'(mul_res_u);
    assign mean_sat = (div_quo > SW'({DATA_WIDTH{1'b1}})) ? {DATA_WIDTH{1'b1}}
                                                          : div_quo[DATA_WIDTH-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            started_reg   <= 1'b0;
            ovf_reg       <= 1'b0;
            count_reg     <= '0;
            sum_reg       <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_load)
                res_valid_reg <= 1'b1;
            else if (!res_stall)
                res_valid_reg <= 1'b0;

            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        started_reg <= 1'b1;
                        state_reg   <= started_reg ? S_PERS : S_FIN;
                    end
                end
                S_PERS:
                    if (mul_done) state_reg <= S_POS;
                S_POS:
                    if (mul_done) state_reg <= model_kind ? S_NEG : S_QSAT;
                S_NEG:
                    if (mul_done) state_reg <= S_QSAT;
                S_QSAT:
                    state_reg <= S_LOSS_GO;
                S_LOSS_GO:
                    state_reg <= S_LOSS;
                S_LOSS:
                begin
                    if (mul_done)
                    begin
                        sum_reg <= (sum_add > SUM_MAX) ? SUM_MAX[SW-1:0] : sum_add[SW-1:0];
                        if (&count_reg)
                            ovf_reg <= 1'b1;
                        else
                            count_reg <= count_reg + 1'b1;
                        state_reg <= S_FIN;
                    end
                end
                S_FIN:
                    state_reg <= div_start ? S_DIV : S_OUT;
                S_DIV:
                    if (div_done) state_reg <= S_OUT;
                S_OUT:
                begin
                    if (out_load)
                    begin
                        if (last_reg)
                        begin
                            started_reg <= 1'b0;
                            ovf_reg     <= 1'b0;
                            count_reg   <= '0;
                            sum_reg     <= '0;
                        end
                        state_reg <= S_IDLE;
                    end
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    r_reg    <= sample;
                    last_reg <= last;
                    acc_reg  <= {{2{intercept[DATA_WIDTH-1]}}, intercept};
                    lv_reg   <= started_reg;
                    if (!started_reg)
                    begin
                        q_reg    <= initial_quantile;
                        loss_reg <= '0;
                    end
                end
            end
            S_PERS, S_POS, S_NEG:
                if (mul_done) acc_reg <= acc_add;
            S_QSAT:
                q_reg <= q_sat;
            S_LOSS:
                if (mul_done) loss_reg <= mul_res_u;
            S_FIN:
            begin
                prev_q_reg <= q_reg;
                prev_r_reg <= r_reg;
                mean_reg   <= '0;
                mv_reg     <= 1'b0;
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    mean_reg <= mean_sat;
                    mv_reg   <= 1'b1;
                end
            end
            default: ;
        endcase

        if (out_load)
        begin
            quantile_reg   <= q_reg;
            loss_term_reg  <= loss_reg;
            loss_valid_reg <= lv_reg;
            mean_loss_reg  <= mean_reg;
            mean_valid_reg <= mv_reg;
            count_ovf_reg  <= ovf_reg;
        end
    end

    assign res_valid      = res_valid_reg;
    assign quantile       = quantile_reg;
    assign loss_term      = loss_term_reg;
    assign loss_valid     = loss_valid_reg;
    assign mean_loss      = mean_loss_reg;
    assign mean_valid     = mean_valid_reg;
    assign count_overflow = count_ovf_reg;

endmodule

>>> rtl/cql_checker.sv
`timescale 1ns / 1ps

module cql_checker #(
    parameter int DATA_WIDTH = cql_pkg::DATA_WIDTH_DEF
) (
    input logic                  clk,
    input logic                  rst_n,
    input logic                  smp_valid,
    input logic                  smp_stall,
    input logic                  res_valid,
    input logic                  res_stall,
    input logic [DATA_WIDTH-1:0] quantile,
    input logic [DATA_WIDTH-1:0] loss_term,
    input logic                  loss_valid,
    input logic [DATA_WIDTH-1:0] mean_loss,
    input logic                  mean_valid
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> res_valid && $stable(quantile) && $stable(mean_loss))
        else $error("result word changed while stalled");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        smp_valid && !smp_stall |=> smp_stall)
        else $error("input not stalled after a sample word was taken");

    a_mean_needs_loss: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && mean_valid |-> loss_valid)
        else $error("mean reported on the first word of a series");

    a_seed_no_loss: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !loss_valid |-> loss_term == '0)
        else $error("loss term nonzero on a seed word");

    a_mean_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !mean_valid |-> mean_loss == '0)
        else $error("mean loss nonzero without mean_valid");

endmodule

bind caviar_quantile_loss_top cql_checker #(.DATA_WIDTH(DATA_WIDTH)) u_cql_checker (.*);
